// File: hdl/awgn_bpsk_llr_channel_unit_defines.svh
// Assertion macros for the channel unit checker.
`ifndef AWGN_BPSK_LLR_CHANNEL_UNIT_DEFINES_SVH
`define AWGN_BPSK_LLR_CHANNEL_UNIT_DEFINES_SVH

// same-cycle implication, quiet during reset
`define AWGN_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("awgn channel check failed");

// next-cycle implication, quiet during reset
`define AWGN_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("awgn channel check failed");

`endif

// File: hdl/awgn_pkg.sv
package awgn_pkg;

    localparam int LOG_STEPS   = 24;
    localparam int SQRT_STEPS  = 28;
    localparam int DIV_STEPS   = 4;
    localparam int RAD_LAT     = LOG_STEPS + 2 + SQRT_STEPS;
    localparam int ANG_LAT     = 2 + 3 * DIV_STEPS + 1;
    localparam int TAIL_LAT    = 4;

    localparam logic [30:0] TWO_LN2_Q30 = 31'd1488522236;
    localparam logic [30:0] HALF_PI_Q30 = 31'd1686629713;
    localparam logic [30:0] ONE_Q30     = 31'h4000_0000;

    localparam logic [15:0] SIGMA_RESET = 16'd4096;
    localparam logic [19:0] GAIN_RESET  = 20'd512;

    // Horner divisors and floor(2^32/d) reciprocals, innermost (highest-order) term first
    localparam logic [6:0]  SIN_DIV   [DIV_STEPS] = '{7'd72, 7'd42, 7'd20, 7'd6};
    localparam logic [6:0]  COS_DIV   [DIV_STEPS] = '{7'd56, 7'd30, 7'd12, 7'd2};
    localparam logic [31:0] SIN_RECIP [DIV_STEPS] =
        '{32'd59652323, 32'd102261126, 32'd214748364, 32'd715827882};
    localparam logic [31:0] COS_RECIP [DIV_STEPS] =
        '{32'd76695844, 32'd143165576, 32'd357913941, 32'd2147483648};

    typedef enum logic {
        REG_NOISE_SIGMA = 1'b0,
        REG_LLR_GAIN    = 1'b1
    } t_reg_idx;

endpackage

// File: hdl/awgn_stream_if.sv
interface awgn_in_if;
    logic        valid;
    logic        ready;
    logic        code_bit;
    logic [31:0] uniform_radius;
    logic [31:0] uniform_angle;

    modport source (output valid, output code_bit, output uniform_radius,
                    output uniform_angle, input ready);
    modport sink   (input valid, input code_bit, input uniform_radius,
                    input uniform_angle, output ready);
endinterface

interface awgn_out_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] noise_sample;
    logic signed [15:0] channel_value;
    logic signed [19:0] soft_value;

    modport source (output valid, output noise_sample, output channel_value,
                    output soft_value, input ready);
    modport sink   (input valid, input noise_sample, input channel_value,
                    input soft_value, output ready);
endinterface

// File: hdl/awgn_radius.sv
// sqrt(-2 ln u1) in Q.24: log2 by squaring, scale by 2 ln 2, restoring square root.
module awgn_radius #(
    parameter int UNIFORM_BITS = 32
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_en,
    input  logic        i_valid,
    input  logic [31:0] i_radius,
    output logic        o_valid,
    output logic [27:0] o_root
);

    localparam int          SHIFT = 32 - UNIFORM_BITS;
    localparam logic [29:0] UB_Q  = 30'(UNIFORM_BITS) << 24;

    typedef struct packed {
        logic [30:0] x;
        logic [5:0]  e;
        logic [23:0] f;
    } t_log_st;

    typedef struct packed {
        logic [55:0] rem;
        logic [55:0] res;
    } t_sq_st;

    t_log_st                      r_lg [awgn_pkg::LOG_STEPS + 1];
    logic [29:0]                  r_v;
    t_sq_st                       r_sq [awgn_pkg::SQRT_STEPS];
    logic [awgn_pkg::RAD_LAT-1:0] r_vld;

    logic [31:0] w_rs;
    logic [32:0] w_m;
    logic [5:0]  w_e;
    logic [62:0] w_sh;
    t_log_st     w_lg0;
    logic [29:0] w_t;
    logic [60:0] w_vp;
    t_sq_st      w_sq0;

    function automatic logic [5:0] lead_one(input logic [32:0] m);
        logic [5:0] e;
        e = '0;
        for (int i = 0; i < 33; i++) begin
            if (m[i]) e = 6'(i);
        end
        return e;
    endfunction

    function automatic t_log_st sq_log(input t_log_st s);
        t_log_st     n;
        logic [61:0] sq;
        logic [31:0] xs;
        sq = 62'(s.x) * 62'(s.x);
        xs = sq[61:30];
        n.e = s.e;
        n.f = {s.f[22:0], xs[31]};
        n.x = xs[31] ? xs[31:1] : xs[30:0];
        return n;
    endfunction

    function automatic t_sq_st sq_root(input t_sq_st s, input logic [55:0] b);
        t_sq_st      n;
        logic [55:0] sum;
        sum = s.res + b;
        if (s.rem >= sum) begin
            n.rem = s.rem - sum;
            n.res = (s.res >> 1) + b;
        end else begin
            n.rem = s.rem;
            n.res = s.res >> 1;
        end
        return n;
    endfunction

    assign w_rs  = i_radius >> SHIFT;
    assign w_m   = {1'b0, w_rs} + 33'd1;
    assign w_e   = lead_one(w_m);
    // leading one lands on bit 30, low bits truncate when e > 30
    assign w_sh  = {w_m, 30'b0} >> w_e;
    assign w_lg0 = '{x: w_sh[30:0], e: w_e, f: 24'b0};

    // -log2 u1 in Q6.24, then times 2 ln 2 with rounding
    assign w_t  = UB_Q - (30'(r_lg[awgn_pkg::LOG_STEPS].e) << 24)
                       - 30'(r_lg[awgn_pkg::LOG_STEPS].f);
    assign w_vp = 61'(w_t) * 61'(awgn_pkg::TWO_LN2_Q30) + (61'(1) << 29);

    assign w_sq0 = '{rem: {2'b0, r_v, 24'b0}, res: 56'b0};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_en) begin
            r_vld <= {r_vld[awgn_pkg::RAD_LAT-2:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_lg[0] <= w_lg0;
            for (int s = 1; s <= awgn_pkg::LOG_STEPS; s++) begin
                r_lg[s] <= sq_log(r_lg[s-1]);
            end
            r_v <= w_vp[59:30];
            r_sq[0] <= sq_root(w_sq0, 56'(1) << 54);
            for (int j = 1; j < awgn_pkg::SQRT_STEPS; j++) begin
                r_sq[j] <= sq_root(r_sq[j-1], 56'(1) << (54 - 2 * j));
            end
        end
    end

    assign o_valid = r_vld[awgn_pkg::RAD_LAT-1];
    assign o_root  = r_sq[awgn_pkg::SQRT_STEPS-1].res[27:0];

endmodule

// File: hdl/awgn_angle.sv
// |cos(2 pi u2)| in Q.30 and its sign, delayed to line up with the radius path.
module awgn_angle #(
    parameter int UNIFORM_BITS = 32
) (
    input  logic        i_clk,
    input  logic        i_en,
    input  logic [31:0] i_angle,
    output logic [30:0] o_mag,
    output logic        o_neg
);

    localparam logic [31:0] AMASK = 32'hFFFF_FFFF << (32 - UNIFORM_BITS);
    localparam int          PAD   = awgn_pkg::RAD_LAT - awgn_pkg::ANG_LAT;

    typedef struct packed {
        logic [29:0] phi;
        logic [29:0] z;
        logic [30:0] a;
        logic [30:0] w;
        logic [30:0] qe;
        logic        ws;
        logic        neg;
    } t_ang_st;

    t_ang_st     r_fold;
    t_ang_st     r_z;
    t_ang_st     r_a [awgn_pkg::DIV_STEPS];
    t_ang_st     r_b [awgn_pkg::DIV_STEPS];
    t_ang_st     r_c [awgn_pkg::DIV_STEPS];
    logic [31:0] r_fin;
    logic [31:0] r_pad [PAD];

    function automatic t_ang_st ang_fold(input logic [31:0] phase);
        t_ang_st     st;
        logic [29:0] r;
        logic [60:0] pr;
        st     = '0;
        r      = phase[29:0];
        st.ws  = phase[30];
        st.neg = phase[31] ^ phase[30];
        // fold the upper half of the quadrant onto [0, pi/4]
        if (r > 30'h2000_0000) begin
            r     = 30'(31'h4000_0000 - {1'b0, r});
            st.ws = !st.ws;
        end
        pr     = 61'(r) * 61'(awgn_pkg::HALF_PI_Q30);
        st.phi = pr[59:30];
        return st;
    endfunction

    function automatic t_ang_st ang_sq(input t_ang_st s);
        t_ang_st     st;
        logic [59:0] pr;
        st   = s;
        pr   = 60'(s.phi) * 60'(s.phi);
        st.z = pr[59:30];
        return st;
    endfunction

    function automatic t_ang_st ang_mul(input t_ang_st s, input logic first);
        t_ang_st     st;
        logic [60:0] pr;
        st = s;
        pr = 61'(s.z) * 61'(s.a);
        st.w = first ? {1'b0, s.z} : pr[60:30];
        return st;
    endfunction

    function automatic t_ang_st ang_recip(input t_ang_st s, input logic [1:0] k);
        t_ang_st     st;
        logic [31:0] m;
        logic [62:0] pr;
        st    = s;
        m     = s.ws ? awgn_pkg::SIN_RECIP[k] : awgn_pkg::COS_RECIP[k];
        pr    = 63'(s.w) * 63'(m);
        st.qe = pr[62:32];
        return st;
    endfunction

    // reciprocal estimate is at most one low
    function automatic t_ang_st ang_fix(input t_ang_st s, input logic [1:0] k);
        t_ang_st     st;
        logic [6:0]  d;
        logic [37:0] rem;
        logic [30:0] q;
        st  = s;
        d   = s.ws ? awgn_pkg::SIN_DIV[k] : awgn_pkg::COS_DIV[k];
        rem = 38'(s.w) - 38'(s.qe) * 38'(d);
        q   = s.qe + ((rem >= 38'(d)) ? 31'd1 : 31'd0);
        st.a = awgn_pkg::ONE_Q30 - q;
        return st;
    endfunction

    function automatic logic [31:0] ang_out(input t_ang_st s);
        logic [60:0] pr;
        pr = 61'(s.phi) * 61'(s.a);
        return {s.neg, s.ws ? pr[60:30] : s.a};
    endfunction

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_fold <= ang_fold(i_angle & AMASK);
            r_z    <= ang_sq(r_fold);
            for (int k = 0; k < awgn_pkg::DIV_STEPS; k++) begin
                r_a[k] <= ang_mul((k == 0) ? r_z : r_c[(k == 0) ? 0 : k - 1], k == 0);
                r_b[k] <= ang_recip(r_a[k], 2'(k));
                r_c[k] <= ang_fix(r_b[k], 2'(k));
            end
            r_fin    <= ang_out(r_c[awgn_pkg::DIV_STEPS-1]);
            r_pad[0] <= r_fin;
            for (int p = 1; p < PAD; p++) begin
                r_pad[p] <= r_pad[p-1];
            end
        end
    end

    assign o_neg = r_pad[PAD-1][31];
    assign o_mag = r_pad[PAD-1][30:0];

endmodule

// File: hdl/awgn_bpsk_llr_channel_unit.sv
// BPSK over AWGN channel emulator. Each input word carries a code bit and two uniform
// words; each output word carries the Box-Muller noise sigma*sqrt(-2 ln u1)*cos(2 pi u2)
// in Q4.12, the channel value (+/-1 plus noise) in Q4.12 and the LLR gain*y in Q12.8,
// all saturated. One word is accepted per clock whenever the output side is not stalled;
// the pipeline depth is set by the 24-step log2 squaring chain and the 28-step square
// root chain on the radius path plus four output stages. A stall on the output freezes
// the whole pipeline. noise_sigma (Q4.12, address 0) and llr_gain (Q12.8, address 4)
// must be written by the user over APB only while the pipeline is empty (not enforced).
module awgn_bpsk_llr_channel_unit #(
    parameter int UNIFORM_BITS = 32
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    awgn_in_if.sink            i_in,
    awgn_out_if.source         o_out,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [2:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready
);

    logic [15:0] r_sigma;
    logic [19:0] r_gain;

    logic        w_en;
    logic        w_rad_vld;
    logic [27:0] w_root;
    logic [30:0] w_mag;
    logic        w_neg;

    logic                          r_bit [awgn_pkg::RAD_LAT];
    logic [awgn_pkg::TAIL_LAT-1:0] r_tv;

    logic [28:0]        r_p;
    logic               r_neg0;
    logic               r_bit0;
    logic signed [22:0] r_n;
    logic               r_bit1;
    logic signed [23:0] r_y;
    logic signed [44:0] r_yg;
    logic signed [22:0] r_n2;
    logic signed [15:0] r_noise;
    logic signed [15:0] r_chan;
    logic signed [19:0] r_soft;

    logic [58:0]        w_pr;
    logic [45:0]        w_ns;
    logic signed [22:0] w_nm;
    logic signed [22:0] w_n;
    logic signed [23:0] w_y;
    logic signed [44:0] w_yg;
    logic [44:0]        w_ymag;
    logic [45:0]        w_lr;
    logic signed [34:0] w_lmag;
    logic signed [34:0] w_llr;

    function automatic logic signed [15:0] sat_q12(input logic signed [23:0] v);
        if (v > 24'sd32767) begin
            return 16'sh7FFF;
        end else if (v < -24'sd32768) begin
            return -16'sd32768;
        end
        return 16'(v);
    endfunction

    function automatic logic signed [19:0] sat_q8(input logic signed [34:0] v);
        if (v > 35'sd524287) begin
            return 20'sh7FFFF;
        end else if (v < -35'sd524288) begin
            return -20'sd524288;
        end
        return 20'(v);
    endfunction

    // configuration port
    assign pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sigma <= awgn_pkg::SIGMA_RESET;
            r_gain  <= awgn_pkg::GAIN_RESET;
        end else if (psel && penable && pwrite) begin
            unique case (awgn_pkg::t_reg_idx'(paddr[2]))
                awgn_pkg::REG_NOISE_SIGMA: r_sigma <= pwdata[15:0];
                awgn_pkg::REG_LLR_GAIN:    r_gain  <= pwdata[19:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (awgn_pkg::t_reg_idx'(paddr[2]))
            awgn_pkg::REG_NOISE_SIGMA: prdata = {16'b0, r_sigma};
            awgn_pkg::REG_LLR_GAIN:    prdata = {12'b0, r_gain};
            default:                   prdata = '0;
        endcase
    end

    // whole pipeline advances unless the output word is held
    assign w_en       = !r_tv[awgn_pkg::TAIL_LAT-1] || o_out.ready;
    assign i_in.ready = w_en;

    awgn_radius #(
        .UNIFORM_BITS (UNIFORM_BITS)
    ) u_radius (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_en     (w_en),
        .i_valid  (i_in.valid),
        .i_radius (i_in.uniform_radius),
        .o_valid  (w_rad_vld),
        .o_root   (w_root)
    );

    awgn_angle #(
        .UNIFORM_BITS (UNIFORM_BITS)
    ) u_angle (
        .i_clk   (i_clk),
        .i_en    (w_en),
        .i_angle (i_in.uniform_angle),
        .o_mag   (w_mag),
        .o_neg   (w_neg)
    );

    assign w_pr   = 59'(w_root) * 59'(w_mag);
    assign w_ns   = 46'(r_p) * 46'(r_sigma) + (46'(1) << 23);
    assign w_nm   = $signed({1'b0, w_ns[45:24]});
    assign w_n    = r_neg0 ? -w_nm : w_nm;
    assign w_y    = 24'(r_n) + (r_bit1 ? -24'sd4096 : 24'sd4096);
    assign w_yg   = 45'(w_y) * 45'($signed({1'b0, r_gain}));
    assign w_ymag = r_yg[44] ? 45'(-r_yg) : 45'(r_yg);
    assign w_lr   = (46'(w_ymag) + (46'(1) << 11)) >> 12;
    assign w_lmag = $signed({1'b0, w_lr[33:0]});
    assign w_llr  = r_yg[44] ? -w_lmag : w_lmag;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tv <= '0;
        end else if (w_en) begin
            r_tv <= {r_tv[awgn_pkg::TAIL_LAT-2:0], w_rad_vld};
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_bit[0] <= i_in.code_bit;
            for (int s = 1; s < awgn_pkg::RAD_LAT; s++) begin
                r_bit[s] <= r_bit[s-1];
            end
            r_p     <= w_pr[58:30];
            r_neg0  <= w_neg;
            r_bit0  <= r_bit[awgn_pkg::RAD_LAT-1];
            r_n     <= w_n;
            r_bit1  <= r_bit0;
            r_y     <= w_y;
            r_yg    <= w_yg;
            r_n2    <= r_n;
            r_noise <= sat_q12(24'(r_n2));
            r_chan  <= sat_q12(r_y);
            r_soft  <= sat_q8(w_llr);
        end
    end

    assign o_out.valid         = r_tv[awgn_pkg::TAIL_LAT-1];
    assign o_out.noise_sample  = r_noise;
    assign o_out.channel_value = r_chan;
    assign o_out.soft_value    = r_soft;

endmodule

// File: hdl/awgn_chk.sv
`include "awgn_bpsk_llr_channel_unit_defines.svh"

module awgn_chk (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_in_valid,
    input logic               i_in_ready,
    input logic               i_out_valid,
    input logic               i_out_ready,
    input logic signed [15:0] i_noise,
    input logic signed [15:0] i_chan,
    input logic signed [19:0] i_soft
);

    logic signed [16:0] w_diff;
    logic               w_small;

    assign w_diff  = 17'(i_chan) - 17'(i_noise);
    assign w_small = (i_noise > -16'sd16384) && (i_noise < 16'sd16384);

    // a held word keeps its payload
    `AWGN_ASSERT_NEXT(a_out_hold, i_out_valid && !i_out_ready, i_out_valid && $stable(i_noise) && $stable(i_chan) && $stable(i_soft))

    // input side moves exactly when the output register can move
    `AWGN_ASSERT_NOW(a_ready_link, i_in_valid || !i_in_valid, i_in_ready == (!i_out_valid || i_out_ready))

    // unsaturated noise: channel value is noise plus or minus one
    `AWGN_ASSERT_NOW(a_symbol_offset, i_out_valid && w_small, w_diff == 17'sd4096 || w_diff == -17'sd4096)

endmodule

bind awgn_bpsk_llr_channel_unit awgn_chk u_awgn_chk (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in.valid),
    .i_in_ready  (i_in.ready),
    .i_out_valid (o_out.valid),
    .i_out_ready (o_out.ready),
    .i_noise     (o_out.noise_sample),
    .i_chan      (o_out.channel_value),
    .i_soft      (o_out.soft_value)
);
